>>> hdl/pafll_pkg.sv
package pafll_pkg;

  localparam int DEFAULT_TABLE_ENTRIES = 64;

  localparam int ADDR_W = 64;
  localparam int TICK_W = 31;
  localparam int CNT_W  = 8;
  localparam int OP_W   = 2;
  localparam int CFG_INDEX_W = 2;

  localparam logic [CNT_W-1:0]  CNT_MAX              = 8'hFF;
  localparam logic [CNT_W-1:0]  RESET_LOGIN_LIMIT    = 8'd3;
  localparam logic [TICK_W-1:0] RESET_WINDOW_TICKS   = 31'd18000;
  localparam logic [TICK_W-1:0] RESET_IDLE_TICKS     = 31'd33000;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY = 2'd0,
    OP_FAIL  = 2'd1,
    OP_SWEEP = 2'd2
  } op_e;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LOGIN_LIMIT = 2'd0,
    CFG_WINDOW      = 2'd1,
    CFG_IDLE        = 2'd2
  } cfg_index_e;

  // operation travelling down the chain, one cell per cycle
  typedef struct packed {
    logic              valid;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    logic              fam;
    logic [TICK_W-1:0] now;
    logic              found;
    logic [CNT_W-1:0]  count;
    logic              free_seen;
  } token_t;

  // new entry written into one cell after a failed login missed
  typedef struct packed {
    logic              valid;
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    logic              fam;
    logic [TICK_W-1:0] now;
  } insert_t;

  // stamps later than now never age out
  function automatic logic aged(logic [TICK_W-1:0] now, logic [TICK_W-1:0] stamp,
                                logic [TICK_W-1:0] limit);
    logic [TICK_W-1:0] age;
    age = now - stamp;
    return (now >= stamp) && (age >= limit);
  endfunction

endpackage

>>> hdl/per_address_failed_login_limiter.sv
// Failed-login limiter keyed by source address.
// Input channel (in_valid_i/in_ready_o) carries one operation: query, record
// failed login, or expiry sweep. Every transaction gives exactly one result
// on the output channel (out_valid_o/out_ready_i).
// Table entries live in a row of TABLE_ENTRIES cells. The operation walks the
// row one cell per cycle; each cell compares, updates or expires its entry as
// the operation passes. A failed login that misses everywhere is written into
// the lowest free cell when it leaves the row.
// The result is ready once the operation has walked the whole row. One
// operation is in flight at a time, so a new item is taken only after the
// last result has moved on to the output register.
// The result sits in an output register; the next item is accepted while it
// waits. If the receiver stalls that long, the finished result is parked and
// no further item is taken until the output register frees up.
// Configuration writes (cfg_valid_i/cfg_ready_o) are always taken and are
// meant only while the block is idle. Reset empties the table and loads the
// default limit, window and idle thresholds.
module per_address_failed_login_limiter #(
  parameter int TABLE_ENTRIES = pafll_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [pafll_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [pafll_pkg::TICK_W-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [pafll_pkg::OP_W-1:0]         opcode_i,
  input  logic [pafll_pkg::ADDR_W-1:0]       addr_high_i,
  input  logic [pafll_pkg::ADDR_W-1:0]       addr_low_i,
  input  logic                               addr_is_v6_i,
  input  logic [pafll_pkg::TICK_W-1:0]       current_tick_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               is_limited_o,
  output logic                               found_o,
  output logic [pafll_pkg::CNT_W-1:0]        failed_count_o,
  output logic                               status_o
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  typedef struct packed {
    logic                          is_limited;
    logic                          found;
    logic [pafll_pkg::CNT_W-1:0]   count;
    logic                          status;
  } res_t;

  state_e                        state_q, state_d;
  logic [pafll_pkg::CNT_W-1:0]   limit_q;
  logic [pafll_pkg::TICK_W-1:0]  window_q, idle_q;
  pafll_pkg::token_t             tok_q;
  pafll_pkg::token_t             tok_chain [TABLE_ENTRIES+1];
  logic [IDX_W-1:0]              idx_chain [TABLE_ENTRIES+1];
  pafll_pkg::token_t             tok_end;
  pafll_pkg::insert_t            ins;
  res_t                          res, hold_q, out_q;
  logic                          out_valid_q;
  logic                          in_acc, end_seen, out_free;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= pafll_pkg::RESET_LOGIN_LIMIT;
      window_q <= pafll_pkg::RESET_WINDOW_TICKS;
      idle_q   <= pafll_pkg::RESET_IDLE_TICKS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pafll_pkg::CFG_LOGIN_LIMIT: limit_q  <= cfg_data_i[pafll_pkg::CNT_W-1:0];
        pafll_pkg::CFG_WINDOW:      window_q <= cfg_data_i;
        pafll_pkg::CFG_IDLE:        idle_q   <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // launch register feeding the first cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q.valid <= 1'b0;
    end else begin
      tok_q.valid <= in_acc;
      if (in_acc) begin
        tok_q.op        <= opcode_i;
        tok_q.hi        <= addr_high_i;
        tok_q.lo        <= addr_low_i;
        tok_q.fam       <= addr_is_v6_i;
        tok_q.now       <= current_tick_i;
        tok_q.found     <= 1'b0;
        tok_q.count     <= '0;
        tok_q.free_seen <= 1'b0;
      end
    end
  end

  assign tok_chain[0] = tok_q;
  assign idx_chain[0] = '0;

  for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
    pafll_cell #(
      .IDX   (g),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (tok_chain[g]),
      .free_idx_i (idx_chain[g]),
      .ins_i      (ins),
      .ins_idx_i  (idx_chain[TABLE_ENTRIES]),
      .window_i   (window_q),
      .idle_i     (idle_q),
      .tok_o      (tok_chain[g+1]),
      .free_idx_o (idx_chain[g+1])
    );
  end

  assign tok_end  = tok_chain[TABLE_ENTRIES];
  assign end_seen = (state_q == ST_RUN) && tok_end.valid;

  always_comb begin
    ins.valid = end_seen && (tok_end.op == pafll_pkg::OP_FAIL) && !tok_end.found &&
                tok_end.free_seen;
    ins.hi    = tok_end.hi;
    ins.lo    = tok_end.lo;
    ins.fam   = tok_end.fam;
    ins.now   = tok_end.now;
  end

  always_comb begin
    res = '0;
    case (tok_end.op)
      pafll_pkg::OP_QUERY: begin
        res.found      = tok_end.found;
        res.count      = tok_end.count;
        res.is_limited = tok_end.found && (tok_end.count > limit_q);
      end
      pafll_pkg::OP_FAIL: begin
        if (tok_end.found) begin
          res.found      = 1'b1;
          res.count      = tok_end.count;
          res.is_limited = tok_end.count > limit_q;
        end else if (tok_end.free_seen) begin
          res.count      = 8'd1;
          res.is_limited = 8'd1 > limit_q;
        end else begin
          res.status     = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_RUN;
      ST_RUN:  if (tok_end.valid) state_d = ST_HOLD;
      ST_HOLD: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_HOLD && out_free) out_valid_q <= 1'b1;
      else if (out_ready_i)               out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (end_seen) hold_q <= res;
    if (state_q == ST_HOLD && out_free) out_q <= hold_q;
  end

  assign out_valid_o    = out_valid_q;
  assign is_limited_o   = out_q.is_limited;
  assign found_o        = out_q.found;
  assign failed_count_o = out_q.count;
  assign status_o       = out_q.status;

  assert property (@(posedge clk_i) disable iff (!rst_ni) $onehot(state_q))
    else $error("state register not one-hot");

  // a transaction reaches the end of the row only while one is in flight
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_end.valid |-> (state_q == ST_RUN))
    else $error("stray token at end of row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_RUN) && tok_q.valid)
    else $error("accepted transaction not launched");

  // a parked result waits while the output is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD && out_valid_q && !out_ready_i) |=> (state_q == ST_HOLD))
    else $error("parked result lost");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (!found_o && (failed_count_o == '0) && !is_limited_o))
    else $error("table-full result carries entry data");

endmodule

>>> hdl/pafll_cell.sv
module pafll_cell #(
  parameter int IDX   = 0,
  parameter int IDX_W = 6
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pafll_pkg::token_t               tok_i,
  input  logic [IDX_W-1:0]                free_idx_i,
  input  pafll_pkg::insert_t              ins_i,
  input  logic [IDX_W-1:0]                ins_idx_i,
  input  logic [pafll_pkg::TICK_W-1:0]    window_i,
  input  logic [pafll_pkg::TICK_W-1:0]    idle_i,
  output pafll_pkg::token_t               tok_o,
  output logic [IDX_W-1:0]                free_idx_o
);

  logic                           valid_q, valid_d;
  logic [pafll_pkg::ADDR_W-1:0]   hi_q, hi_d, lo_q, lo_d;
  logic                           fam_q, fam_d;
  logic [pafll_pkg::TICK_W-1:0]   seen_q, seen_d, fail_q, fail_d;
  logic [pafll_pkg::CNT_W-1:0]    cnt_q, cnt_d, cnt_inc;
  pafll_pkg::token_t              tok_q, tok_d;
  logic [IDX_W-1:0]               idx_q, idx_d;
  logic                           match;

  assign match = valid_q && (fam_q == tok_i.fam) && (hi_q == tok_i.hi) && (lo_q == tok_i.lo);
  assign cnt_inc = (cnt_q == pafll_pkg::CNT_MAX) ? cnt_q : cnt_q + 8'd1;

  always_comb begin
    valid_d = valid_q;
    hi_d    = hi_q;
    lo_d    = lo_q;
    fam_d   = fam_q;
    seen_d  = seen_q;
    fail_d  = fail_q;
    cnt_d   = cnt_q;
    tok_d   = tok_i;
    idx_d   = free_idx_i;

    if (tok_i.valid) begin
      if (!valid_q && !tok_i.free_seen) begin
        tok_d.free_seen = 1'b1;
        idx_d           = IDX_W'(IDX);
      end
      case (tok_i.op)
        pafll_pkg::OP_QUERY: begin
          if (match) begin
            tok_d.found = 1'b1;
            tok_d.count = cnt_q;
          end
        end
        pafll_pkg::OP_FAIL: begin
          if (match) begin
            cnt_d       = cnt_inc;
            seen_d      = tok_i.now;
            fail_d      = tok_i.now;
            tok_d.found = 1'b1;
            tok_d.count = cnt_inc;
          end
        end
        pafll_pkg::OP_SWEEP: begin
          if (valid_q) begin
            if ((fail_q != '0) && pafll_pkg::aged(tok_i.now, fail_q, window_i)) begin
              fail_d = '0;
              cnt_d  = '0;
            end
            if (pafll_pkg::aged(tok_i.now, seen_q, idle_i)) valid_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end

    if (ins_i.valid && (ins_idx_i == IDX_W'(IDX))) begin
      valid_d = 1'b1;
      hi_d    = ins_i.hi;
      lo_d    = ins_i.lo;
      fam_d   = ins_i.fam;
      seen_d  = ins_i.now;
      fail_d  = ins_i.now;
      cnt_d   = 8'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      tok_q.valid <= 1'b0;
    end else begin
      valid_q <= valid_d;
      tok_q   <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    fam_q  <= fam_d;
    seen_q <= seen_d;
    fail_q <= fail_d;
    cnt_q  <= cnt_d;
    idx_q  <= idx_d;
  end

  assign tok_o      = tok_q;
  assign free_idx_o = idx_q;

  // an insert only targets a free cell
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ins_i.valid && (ins_idx_i == IDX_W'(IDX))) |-> !valid_q)
    else $error("insert into occupied cell");

  // a matching failed login bumps the count unless saturated
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_i.valid && (tok_i.op == pafll_pkg::OP_FAIL) && match && (cnt_q != pafll_pkg::CNT_MAX))
    |=> (cnt_q == $past(cnt_q) + 8'd1))
    else $error("failed login count not incremented");

  // a query never changes the entry
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_i.valid && (tok_i.op == pafll_pkg::OP_QUERY) && !ins_i.valid) |=> $stable(cnt_q))
    else $error("query modified count");

endmodule

>>> tb/login_limiter_checker.sv
`timescale 1ns / 100ps

module login_limiter_checker #(
  parameter int TABLE_ENTRIES = pafll_pkg::DEFAULT_TABLE_ENTRIES
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [pafll_pkg::CFG_INDEX_W-1:0]  cfg_index_i,
  input  logic [pafll_pkg::TICK_W-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  input  logic                               in_ready_i,
  input  logic [pafll_pkg::OP_W-1:0]         opcode_i,
  input  logic [pafll_pkg::ADDR_W-1:0]       addr_high_i,
  input  logic [pafll_pkg::ADDR_W-1:0]       addr_low_i,
  input  logic                               addr_is_v6_i,
  input  logic [pafll_pkg::TICK_W-1:0]       current_tick_i,
  input  logic                               out_valid_i,
  input  logic                               out_ready_i,
  input  logic                               is_limited_i,
  input  logic                               found_i,
  input  logic [pafll_pkg::CNT_W-1:0]        failed_count_i,
  input  logic                               status_i,
  output int                                 pending_results_o,
  output int                                 mismatch_total_o
);
  import pafll_pkg::*;

  typedef struct packed {
    logic             limited;
    logic             found;
    logic [CNT_W-1:0] count;
    logic             status;
  } verdict_t;

  // shadow of the address table
  logic              tbl_valid     [TABLE_ENTRIES];
  logic [ADDR_W-1:0] tbl_hi        [TABLE_ENTRIES];
  logic [ADDR_W-1:0] tbl_lo        [TABLE_ENTRIES];
  logic              tbl_fam       [TABLE_ENTRIES];
  logic [TICK_W-1:0] tbl_seen      [TABLE_ENTRIES];
  logic [TICK_W-1:0] tbl_fail_tick [TABLE_ENTRIES];
  logic [CNT_W-1:0]  tbl_count     [TABLE_ENTRIES];

  logic [CNT_W-1:0]  limit_r;
  logic [TICK_W-1:0] window_r;
  logic [TICK_W-1:0] idle_r;

  verdict_t expected_verdicts[$];
  int       fails_seen = 0;

  assign mismatch_total_o = fails_seen;

  task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                 input logic [CNT_W-1:0] want);
    if (fails_seen < 40) begin
      $display("[%0t] %s: got %0h, expected %0h", $time, what, got, want);
    end
    fails_seen++;
  endtask

  // a stamp later than now has a negative age and never goes stale
  function automatic logic stale(input logic [TICK_W-1:0] now, input logic [TICK_W-1:0] stamp,
                                 input logic [TICK_W-1:0] threshold);
    return (now >= stamp) && ((now - stamp) >= threshold);
  endfunction

  function automatic int find_slot(input logic [ADDR_W-1:0] hi, input logic [ADDR_W-1:0] lo,
                                   input logic fam);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_fam[i] == fam && tbl_hi[i] == hi && tbl_lo[i] == lo) begin
        return i;
      end
    end
    return -1;
  endfunction

  task automatic run_table_op(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] hi,
                              input logic [ADDR_W-1:0] lo, input logic fam,
                              input logic [TICK_W-1:0] now, output verdict_t v);
    int slot;
    v    = '0;
    slot = -1;
    case (op)
      OP_QUERY: begin
        slot = find_slot(hi, lo, fam);
        if (slot >= 0) begin
          v.found   = 1'b1;
          v.count   = tbl_count[slot];
          v.limited = tbl_count[slot] > limit_r;
        end
      end
      OP_FAIL: begin
        slot = find_slot(hi, lo, fam);
        if (slot >= 0) begin
          v.found = 1'b1;
          if (tbl_count[slot] != CNT_MAX) begin
            tbl_count[slot] = tbl_count[slot] + 8'd1;
          end
        end else begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot < 0 && !tbl_valid[i]) begin
              slot = i;
            end
          end
          if (slot >= 0) begin
            tbl_valid[slot] = 1'b1;
            tbl_hi[slot]    = hi;
            tbl_lo[slot]    = lo;
            tbl_fam[slot]   = fam;
            tbl_count[slot] = 8'd1;
          end else begin
            v.status = 1'b1;
          end
        end
        if (slot >= 0) begin
          tbl_seen[slot]      = now;
          tbl_fail_tick[slot] = now;
          v.count             = tbl_count[slot];
          v.limited           = tbl_count[slot] > limit_r;
        end
      end
      OP_SWEEP: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (tbl_valid[i]) begin
            // a zero failure stamp is unset and never ages out
            if (tbl_fail_tick[i] != '0 && stale(now, tbl_fail_tick[i], window_r)) begin
              tbl_fail_tick[i] = '0;
              tbl_count[i]     = '0;
            end
            if (stale(now, tbl_seen[i], idle_r)) begin
              tbl_valid[i] = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    verdict_t fresh;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        tbl_valid[i] = 1'b0;
      end
      limit_r  = RESET_LOGIN_LIMIT;
      window_r = RESET_WINDOW_TICKS;
      idle_r   = RESET_IDLE_TICKS;
      expected_verdicts.delete();
      pending_results_o <= 0;
    end else begin
      // results first: a result leaving now belongs to an older transaction
      if (out_valid_i && out_ready_i) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result with no transaction pending", 8'd1, 8'd0);
        end else begin
          want = expected_verdicts.pop_front();
          if (is_limited_i !== want.limited) begin
            report_mismatch("is_limited", CNT_W'(is_limited_i), CNT_W'(want.limited));
          end
          if (found_i !== want.found) begin
            report_mismatch("found", CNT_W'(found_i), CNT_W'(want.found));
          end
          if (failed_count_i !== want.count) begin
            report_mismatch("failed_count", failed_count_i, want.count);
          end
          if (status_i !== want.status) begin
            report_mismatch("status", CNT_W'(status_i), CNT_W'(want.status));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_LOGIN_LIMIT: limit_r  = cfg_data_i[CNT_W-1:0];
          CFG_WINDOW:      window_r = cfg_data_i;
          CFG_IDLE:        idle_r   = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        run_table_op(opcode_i, addr_high_i, addr_low_i, addr_is_v6_i, current_tick_i, fresh);
        expected_verdicts.push_back(fresh);
      end
      pending_results_o <= expected_verdicts.size();
    end
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pafll_pkg::*;

  localparam int ENTRIES      = DEFAULT_TABLE_ENTRIES;
  localparam int LATENCY      = ENTRIES + 2;
  localparam int DRAIN_CYCLES = 2 * LATENCY + 16;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int POOL_SIZE    = 100;
  localparam int PHASES       = 11;

  localparam logic [OP_W-1:0]        OP_SPARE  = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [TICK_W-1:0]      TICK_MAX  = '1;

  typedef struct packed {
    logic [ADDR_W-1:0] hi;
    logic [ADDR_W-1:0] lo;
    logic              v6;
  } src_addr_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i;
  logic [TICK_W-1:0]      cfg_data_i;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [OP_W-1:0]        opcode_i;
  logic [ADDR_W-1:0]      addr_high_i;
  logic [ADDR_W-1:0]      addr_low_i;
  logic                   addr_is_v6_i;
  logic [TICK_W-1:0]      current_tick_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic                   is_limited_o;
  logic                   found_o;
  logic [CNT_W-1:0]       failed_count_o;
  logic                   status_o;

  int pending_results;
  int mismatch_total;

  src_addr_t         addr_pool[POOL_SIZE];
  logic [TICK_W-1:0] tick_now;
  int                step_max;
  bit                gaps_on;
  bit                stalls_on;
  int                stall_left;

  per_address_failed_login_limiter #(
    .TABLE_ENTRIES(ENTRIES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .addr_high_i   (addr_high_i),
    .addr_low_i    (addr_low_i),
    .addr_is_v6_i  (addr_is_v6_i),
    .current_tick_i(current_tick_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .is_limited_o  (is_limited_o),
    .found_o       (found_o),
    .failed_count_o(failed_count_o),
    .status_o      (status_o)
  );

  login_limiter_checker #(
    .TABLE_ENTRIES(ENTRIES)
  ) u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_i      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .opcode_i         (opcode_i),
    .addr_high_i      (addr_high_i),
    .addr_low_i       (addr_low_i),
    .addr_is_v6_i     (addr_is_v6_i),
    .current_tick_i   (current_tick_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .is_limited_i     (is_limited_o),
    .found_i          (found_o),
    .failed_count_i   (failed_count_o),
    .status_i         (status_o),
    .pending_results_o(pending_results),
    .mismatch_total_o (mismatch_total)
  );

  always #4 clk_i = ~clk_i;

  // receiver back-pressure in bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= (stall_left == 1);
    end else if (stalls_on && $urandom_range(0, 19) == 0) begin
      stall_left  <= $urandom_range(1, 15);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand_wide();
    return {$urandom, $urandom};
  endfunction

  task automatic push_request(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] hi,
                              input logic [ADDR_W-1:0] lo, input logic fam,
                              input logic [TICK_W-1:0] tick);
    int gap;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 15);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    opcode_i       <= op;
    addr_high_i    <= hi;
    addr_low_i     <= lo;
    addr_is_v6_i   <= fam;
    current_tick_i <= tick;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic push_pool(input logic [OP_W-1:0] op, input int idx,
                           input logic [TICK_W-1:0] tick);
    push_request(op, addr_pool[idx].hi, addr_pool[idx].lo, addr_pool[idx].v6, tick);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [TICK_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // wait until every result is back, plus a short pause before touching registers
  task automatic settle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic advance_tick(input int span);
    tick_now = tick_now + TICK_W'($urandom_range(0, span));
  endtask

  // mixed traffic over the first hot+1 pool addresses
  task automatic churn_item(input int hot);
    int                r;
    int                idx;
    logic [31:0]       rnd;
    logic [TICK_W-1:0] t;
    r   = $urandom_range(0, 99);
    idx = $urandom_range(0, hot);
    rnd = $urandom;
    advance_tick(step_max);
    // now and then a tick far off, ahead or behind the stamps
    t = ($urandom_range(0, 49) == 0) ? rnd[TICK_W-1:0] : tick_now;
    if (r < 35) begin
      push_pool(OP_QUERY, idx, t);
    end else if (r < 75) begin
      push_pool(OP_FAIL, idx, t);
    end else if (r < 88) begin
      push_pool(OP_SWEEP, idx, t);
    end else if (r < 92) begin
      push_request(OP_SPARE, rand_wide(), rand_wide(), rnd[31], rnd[TICK_W-1:0]);
    end else begin
      push_request(rnd[31:30], rand_wide(), rand_wide(), rnd[29], t);
    end
  endtask

  initial begin
    int                ph;
    int                hot;
    int                lim;
    int                win;
    int                idl;
    int                pos;
    int                r;
    logic [31:0]       junk;
    src_addr_t         src;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_LOGIN_LIMIT;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    opcode_i       = OP_QUERY;
    addr_high_i    = '0;
    addr_low_i     = '0;
    addr_is_v6_i   = 1'b0;
    current_tick_i = '0;
    out_ready_i    = 1'b0;
    stall_left     = 0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    step_max       = 100;
    tick_now       = TICK_W'($urandom_range(1, 1000));

    // pool: v4, v6, and near twins that differ in family or in one address bit
    for (int k = 0; k < POOL_SIZE; k++) begin
      case (k % 4)
        0: begin
          src.hi = '0;
          src.lo = {32'd0, $urandom};
          src.v6 = 1'b0;
        end
        1: begin
          src.hi = rand_wide();
          src.lo = rand_wide();
          src.v6 = 1'b1;
        end
        2: begin
          src    = addr_pool[k-1];
          src.v6 = ~src.v6;
        end
        default: begin
          src = addr_pool[k-1];
          pos = $urandom_range(0, ADDR_W-1);
          if ($urandom_range(0, 1) != 0) begin
            src.hi = src.hi ^ (64'd1 << pos);
          end else begin
            src.lo = src.lo ^ (64'd1 << pos);
          end
        end
      endcase
      addr_pool[k] = src;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed checks at the reset register values
    push_request(OP_QUERY, '0, '0, 1'b0, '0);
    push_request(OP_FAIL, '1, '1, 1'b1, TICK_MAX);
    push_request(OP_QUERY, '1, '1, 1'b1, TICK_MAX);
    push_request(OP_FAIL, '1, '1, 1'b0, TICK_MAX);
    push_request(OP_FAIL, ~64'd1, '1, 1'b1, TICK_MAX);
    push_request(OP_FAIL, '1, {1'b0, {63{1'b1}}}, 1'b1, TICK_MAX);
    repeat (3) push_request(OP_FAIL, '1, '1, 1'b1, TICK_MAX);
    push_request(OP_QUERY, '1, '1, 1'b1, TICK_MAX);
    // failure stamped at tick zero stays unset, so its count survives the window
    push_request(OP_FAIL, '0, '0, 1'b0, '0);
    push_request(OP_SWEEP, '0, '0, 1'b0, 31'd20000);
    push_request(OP_QUERY, '0, '0, 1'b0, 31'd20000);
    push_request(OP_SWEEP, '0, '0, 1'b0, 31'd40000);
    push_request(OP_QUERY, '0, '0, 1'b0, 31'd40000);
    // window and idle boundaries
    push_request(OP_FAIL, '0, 64'h0A00_0001, 1'b0, 31'd100);
    push_request(OP_SWEEP, '0, '0, 1'b0, 31'd18099);
    push_request(OP_SWEEP, '0, '0, 1'b0, 31'd18100);
    push_request(OP_QUERY, '0, 64'h0A00_0001, 1'b0, 31'd18100);
    push_request(OP_SWEEP, '0, '0, 1'b0, 31'd33099);
    push_request(OP_SWEEP, '0, '0, 1'b0, 31'd33100);
    push_request(OP_QUERY, '0, 64'h0A00_0001, 1'b0, 31'd33100);
    push_request(OP_SPARE, rand_wide(), rand_wide(), 1'b1, TICK_W'($urandom));
    push_request(OP_SWEEP, '0, '0, 1'b0, TICK_MAX);
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == PHASES - 1) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
      end
      junk = $urandom;
      case (ph)
        1, 7: begin
          // fill the table past its size with the counts held forever
          write_reg(CFG_LOGIN_LIMIT, '0);
          write_reg(CFG_WINDOW, TICK_MAX);
          write_reg(CFG_IDLE, TICK_MAX);
          for (int k = 0; k < 130; k++) begin
            r = $urandom_range(0, 99);
            advance_tick(5);
            if (r < 75) begin
              push_pool(OP_FAIL, k % POOL_SIZE, tick_now);
            end else if (r < 95) begin
              push_pool(OP_QUERY, $urandom_range(0, POOL_SIZE-1), tick_now);
            end else begin
              push_pool(OP_SWEEP, 0, tick_now);
            end
          end
        end
        2, 5: begin
          // zero window and idle: the last sweep at the top tick empties the table
          write_reg(CFG_WINDOW, '0);
          write_reg(CFG_IDLE, '0);
          for (int k = 0; k < 12; k++) begin
            advance_tick(50);
            case (k % 4)
              0: push_pool(OP_SWEEP, 0, tick_now);
              1: push_pool(OP_QUERY, $urandom_range(0, POOL_SIZE-1), tick_now);
              2: push_pool(OP_FAIL, $urandom_range(0, POOL_SIZE-1), tick_now);
              default: push_pool(OP_SWEEP, 0, (k == 11) ? TICK_MAX : tick_now);
            endcase
          end
        end
        3: begin
          // drive one address into count saturation
          write_reg(CFG_LOGIN_LIMIT, 31'd255);
          write_reg(CFG_WINDOW, TICK_MAX);
          write_reg(CFG_IDLE, TICK_MAX);
          for (int k = 0; k < 320; k++) begin
            r = $urandom_range(0, 99);
            advance_tick(3);
            if (r < 90) begin
              push_pool(OP_FAIL, 0, tick_now);
            end else if (r < 96) begin
              push_pool(OP_QUERY, $urandom_range(0, 1), tick_now);
            end else begin
              push_pool(OP_SWEEP, 0, tick_now);
            end
          end
        end
        4, 9: begin
          // tiny window and idle: counts and entries age out almost at once
          write_reg(CFG_LOGIN_LIMIT, TICK_W'($urandom_range(0, 3)));
          write_reg(CFG_WINDOW, 31'd1);
          write_reg(CFG_IDLE, (ph == 4) ? 31'd1 : TICK_W'($urandom_range(2, 50)));
          step_max = 20;
          for (int k = 0; k < 160; k++) churn_item(30);
        end
        default: begin
          lim = $urandom_range(0, 6);
          win = $urandom_range(40, 3000);
          idl = $urandom_range(win / 2 + 1, 6000);
          // every phase here is even, so zeros go above the limit field
          write_reg(CFG_LOGIN_LIMIT,
                    {(ph % 2 == 1) ? junk[TICK_W-CNT_W-1:0] : '0, CNT_W'(lim)});
          write_reg(CFG_WINDOW, TICK_W'(win));
          write_reg(CFG_IDLE, TICK_W'(idl));
          if (ph == 0) begin
            write_reg(CFG_SPARE, junk[TICK_W-1:0]);
          end
          step_max = win / 8 + 1;
          hot      = $urandom_range(20, POOL_SIZE - 1);
          for (int k = 0; k < ((ph == PHASES - 1) ? 200 : 160); k++) churn_item(hot);
        end
      endcase
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_total == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> per_address_failed_login_limiter.f
hdl/pafll_pkg.sv
hdl/pafll_cell.sv
hdl/per_address_failed_login_limiter.sv
tb/login_limiter_checker.sv
tb/tb_top.sv
